@@ design/drbs_pkg.sv @@
`default_nettype none
package drbs_pkg;

  localparam int BANKS_DEF       = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int ROW_BITS_DEF    = 16;
  localparam int TIME_BITS_DEF   = 32;

  localparam int CFG_AW = 5;

  localparam logic [15:0] HIT_LAT_RST    = 16'd154;
  localparam logic [15:0] CLOSED_LAT_RST = 16'd258;
  localparam logic [15:0] MISS_LAT_RST   = 16'd362;
  localparam logic [15:0] ISSUE_DLY_RST  = 16'd135;

  typedef enum logic [2:0] {
    REG_HIT_LAT    = 3'd0,
    REG_CLOSED_LAT = 3'd1,
    REG_MISS_LAT   = 3'd2,
    REG_ISSUE_DLY  = 3'd3,
    REG_REORDER    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_HIT     = 3'd0,
    EV_CLOSED  = 3'd1,
    EV_MISS    = 3'd2,
    EV_QUEUED  = 3'd3,
    EV_DROPPED = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SYNC,
    ST_FINAL
  } seq_state_t;

  typedef struct packed {
    logic [TIME_BITS_DEF-1:0] arrival_time;
    logic [1:0]               request_bank;
    logic [ROW_BITS_DEF-1:0]  request_row;
  } in_t;

  typedef struct packed {
    logic [1:0]               event_bank;
    ev_kind_t                 event_kind;
    logic [ROW_BITS_DEF-1:0]  event_row;
    logic [TIME_BITS_DEF-1:0] start_time;
    logic [TIME_BITS_DEF-1:0] end_time;
    logic [31:0]              bank_busy_total;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic        valid;
    out_t        payload;
  } evt_t;

  typedef struct packed {
    logic [15:0] hit_latency;
    logic [15:0] closed_latency;
    logic [15:0] miss_latency;
    logic        reorder_enable;
  } cell_cfg_t;

endpackage
`default_nettype wire

@@ design/drbs_bank_cell.sv @@
`default_nettype none
module drbs_bank_cell #(
  parameter int IDX         = 0,
  parameter int QUEUE_DEPTH = 8,
  parameter int ROW_BITS    = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  drbs_pkg::cell_cfg_t       cfg,
  input  wire [TIME_BITS-1:0]       now,
  input  wire [TIME_BITS-1:0]       issue,
  input  wire [ROW_BITS-1:0]        req_row,
  input  wire                       fin,
  input  wire                       token_in,
  output logic                      token_out,
  output drbs_pkg::evt_t            ev
);
  import drbs_pkg::*;

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [ROW_BITS-1:0]  open_row_r, open_row_nxt;
  logic                 row_valid_r, row_valid_nxt;
  logic [TIME_BITS-1:0] busy_until_r, busy_until_nxt;
  logic [31:0]          busy_sum_r, busy_sum_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 token_r, token_nxt;
  logic [ROW_BITS-1:0]  q_r   [QUEUE_DEPTH];
  logic [ROW_BITS-1:0]  q_nxt [QUEUE_DEPTH];

  logic                 still_busy;
  logic [QW-1:0]        sel;
  logic [ROW_BITS-1:0]  svc_row;
  logic [TIME_BITS-1:0] svc_start;
  logic                 do_serve, do_pop;
  logic [15:0]          lat;
  ev_kind_t             kind;
  logic [TIME_BITS:0]   end_sum;
  logic [TIME_BITS-1:0] end_time;
  logic [32:0]          tot_sum;
  logic [31:0]          tot;

  assign still_busy = busy_until_r > now;

  // Oldest row hit behind a non-hit head, searched only when reordering applies.
  always_comb begin
    sel = '0;
    if (cfg.reorder_enable && count_r >= CW'(2) &&
        !(row_valid_r && q_r[0] == open_row_r)) begin
      for (int p = QUEUE_DEPTH - 1; p >= 1; p--) begin
        if (CW'(p) < count_r && row_valid_r && q_r[p] == open_row_r) begin
          sel = QW'(p);
        end
      end
    end
  end

  assign do_pop    = token_r && !still_busy && count_r != '0;
  assign do_serve  = do_pop || (fin && !still_busy);
  assign svc_row   = do_pop ? q_r[sel] : req_row;
  assign svc_start = do_pop ? busy_until_r : issue;
  assign token_out = token_r && !do_pop;

  always_comb begin
    if (row_valid_r && open_row_r == svc_row) begin
      kind = EV_HIT;
      lat  = cfg.hit_latency;
    end else if (!row_valid_r) begin
      kind = EV_CLOSED;
      lat  = cfg.closed_latency;
    end else begin
      kind = EV_MISS;
      lat  = cfg.miss_latency;
    end
    end_sum  = {1'b0, svc_start} + (TIME_BITS + 1)'(lat);
    end_time = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
    tot_sum  = {1'b0, busy_sum_r} + 33'(lat);
    tot      = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
  end

  always_comb begin
    open_row_nxt   = open_row_r;
    row_valid_nxt  = row_valid_r;
    busy_until_nxt = busy_until_r;
    busy_sum_nxt   = busy_sum_r;
    count_nxt      = count_r;
    token_nxt      = token_in || do_pop;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (do_serve) begin
      open_row_nxt   = svc_row;
      row_valid_nxt  = 1'b1;
      busy_until_nxt = end_time;
      busy_sum_nxt   = tot;
    end
    if (do_pop) begin
      count_nxt = count_r - CW'(1);
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (QW'(i) >= sel) begin
          q_nxt[i] = q_r[i + 1];
        end
      end
    end else if (fin && still_busy && count_r != CW'(QUEUE_DEPTH)) begin
      q_nxt[count_r[QW-1:0]] = req_row;
      count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    ev = '0;
    ev.valid                   = do_pop || fin;
    ev.payload.event_bank      = 2'(IDX);
    ev.payload.event_row       = 16'(svc_row);
    ev.payload.start_time      = 32'(svc_start);
    ev.payload.last            = fin;
    if (do_serve) begin
      ev.payload.event_kind      = kind;
      ev.payload.end_time        = 32'(end_time);
      ev.payload.bank_busy_total = tot;
    end else begin
      ev.payload.event_kind      = (count_r == CW'(QUEUE_DEPTH)) ? EV_DROPPED : EV_QUEUED;
      ev.payload.end_time        = '0;
      ev.payload.bank_busy_total = busy_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_row_r   <= '0;
      row_valid_r  <= 1'b0;
      busy_until_r <= '0;
      busy_sum_r   <= '0;
      count_r      <= '0;
      token_r      <= 1'b0;
    end else begin
      open_row_r   <= open_row_nxt;
      row_valid_r  <= row_valid_nxt;
      busy_until_r <= busy_until_nxt;
      busy_sum_r   <= busy_sum_nxt;
      count_r      <= count_nxt;
      token_r      <= token_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule
`default_nettype wire

@@ design/dram_bank_row_buffer_scheduler_top.sv @@
`default_nettype none
// DRAM open-page bank scheduler.
// A request (arrival time, bank, row) is taken with start while busy is low.
// The banks form a chain of cells; a token walks the chain from bank 0 up.
// The cell holding the token serves the head of its queue (the oldest row hit
// when reorder is on and the head is no hit), one access per cycle while the
// bank is free by the arrival time, then hands the token on. After the last bank
// the request itself is issued, queued or dropped by its own bank; that event
// carries last. Each event appears for one cycle with out_valid; the receiver
// cannot stall. Busy stays high from the accepting edge until the final event
// has been shown. Results come one per cycle while accesses are served, the
// last event in the final cycle.
// Latencies, issue delay and reorder mode are written through the APB port at
// byte address 4*index; the user must write them only while the block is idle,
// which the block itself does not enforce. Reset clears all banks to closed,
// idle, with empty queues and default register values.
module dram_bank_row_buffer_scheduler_top #(
  parameter int BANKS       = drbs_pkg::BANKS_DEF,
  parameter int QUEUE_DEPTH = drbs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        start,
  output logic                       busy,
  input  drbs_pkg::in_t              in_payload,
  output logic                       out_valid,
  output drbs_pkg::out_t             out_payload,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [drbs_pkg::CFG_AW-1:0] paddr,
  input  wire [31:0]                 pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import drbs_pkg::*;

  localparam int ROW_BITS  = ROW_BITS_DEF;
  localparam int TIME_BITS = TIME_BITS_DEF;
  localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;

  logic [15:0]          hit_lat_r, closed_lat_r, miss_lat_r, issue_dly_r;
  logic                 reorder_r;
  seq_state_t           state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r;
  logic [ROW_BITS-1:0]  row_r;
  logic [BW-1:0]        bsel_r;
  logic [4:0]           bank_mod;
  logic                 accept, wr;
  logic [TIME_BITS:0]   issue_sum;
  logic [TIME_BITS-1:0] issue;
  cell_cfg_t            ccfg;
  logic [BANKS:0]       tok;
  evt_t                 ev [BANKS];
  logic [BANKS-1:0]     ev_valid;
  reg_idx_t             ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_lat_r    <= HIT_LAT_RST;
      closed_lat_r <= CLOSED_LAT_RST;
      miss_lat_r   <= MISS_LAT_RST;
      issue_dly_r  <= ISSUE_DLY_RST;
      reorder_r    <= 1'b0;
    end else if (wr) begin
      unique case (ridx)
        REG_HIT_LAT:    hit_lat_r    <= pwdata[15:0];
        REG_CLOSED_LAT: closed_lat_r <= pwdata[15:0];
        REG_MISS_LAT:   miss_lat_r   <= pwdata[15:0];
        REG_ISSUE_DLY:  issue_dly_r  <= pwdata[15:0];
        REG_REORDER:    reorder_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_HIT_LAT:    prdata = {16'd0, hit_lat_r};
      REG_CLOSED_LAT: prdata = {16'd0, closed_lat_r};
      REG_MISS_LAT:   prdata = {16'd0, miss_lat_r};
      REG_ISSUE_DLY:  prdata = {16'd0, issue_dly_r};
      REG_REORDER:    prdata = {31'd0, reorder_r};
      default:        prdata = '0;
    endcase
  end

  // Bank number folded into range; the field is only two bits wide.
  always_comb begin
    bank_mod = {3'd0, in_payload.request_bank};
    for (int k = 0; k < 3; k++) begin
      if (bank_mod >= 5'(BANKS)) begin
        bank_mod = bank_mod - 5'(BANKS);
      end
    end
  end

  assign accept = start && !busy;

  always_comb begin
    unique case (state_r)
      ST_IDLE:  state_nxt = accept ? ST_SYNC : ST_IDLE;
      ST_SYNC:  state_nxt = tok[BANKS] ? ST_FINAL : ST_SYNC;
      ST_FINAL: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r  <= TIME_BITS'(in_payload.arrival_time);
      row_r  <= ROW_BITS'(in_payload.request_row);
      bsel_r <= BW'(bank_mod);
    end
  end

  assign issue_sum = {1'b0, now_r} + (TIME_BITS + 1)'(issue_dly_r);
  assign issue     = issue_sum[TIME_BITS] ? '1 : issue_sum[TIME_BITS-1:0];

  assign ccfg.hit_latency    = hit_lat_r;
  assign ccfg.closed_latency = closed_lat_r;
  assign ccfg.miss_latency   = miss_lat_r;
  assign ccfg.reorder_enable = reorder_r;

  assign tok[0] = accept;

  for (genvar c = 0; c < BANKS; c++) begin : g_cell
    drbs_bank_cell #(
      .IDX         (c),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ROW_BITS    (ROW_BITS),
      .TIME_BITS   (TIME_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg       (ccfg),
      .now       (now_r),
      .issue     (issue),
      .req_row   (row_r),
      .fin       ((state_r == ST_FINAL) && (bsel_r == BW'(c))),
      .token_in  (tok[c]),
      .token_out (tok[c+1]),
      .ev        (ev[c])
    );
    assign ev_valid[c] = ev[c].valid;
  end

  // Idle cells still present their bank and row, so only a valid beat is merged.
  always_comb begin
    out_valid   = 1'b0;
    out_payload = '0;
    for (int c = 0; c < BANKS; c++) begin
      out_valid = out_valid | ev[c].valid;
      if (ev[c].valid) begin
        out_payload = out_payload | ev[c].payload;
      end
    end
  end

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ev_valid))
    else $error("two bank cells drive an event in one cycle");

  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("more than one token handoff in one cycle");

  a_event_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("event shown while idle");

  a_last_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.last) |=> !busy)
    else $error("final event not followed by idle");

endmodule
`default_nettype wire
